/* hdl/fnr50_pkg.sv */
package fnr50_pkg;

    // Radix-50 codes of the special characters
    localparam logic [5:0] R50_NONE       = 6'd0;
    localparam logic [5:0] CODE_DOLLAR    = 6'd27;
    localparam logic [5:0] R50_DOT        = 6'd28;
    localparam logic [5:0] CODE_PERCENT   = 6'd29;
    localparam logic [5:0] R50_DIGIT_BASE = 6'd30;

    // Character weights inside one word
    localparam logic [15:0] W_FIRST  = 16'd1600;
    localparam logic [15:0] W_SECOND = 16'd40;

    // Character position milestones
    localparam logic [3:0] POS_SECOND_WORD = 4'd3;
    localparam logic [3:0] POS_NAME_FULL   = 4'd6;
    localparam logic [3:0] POS_TYPE_START  = 4'd7;
    localparam logic [3:0] POS_TYPE_FULL   = 4'd10;

    localparam logic [7:0] ASCII_SLASH = 8'h2F;

    typedef logic [5:0]  t_r50_code;
    typedef logic [15:0] t_r50_word;

    // Map one ASCII byte to its Radix-50 code; R50_NONE marks an illegal byte
    function automatic t_r50_code r50_code(input logic [7:0] c);
        t_r50_code code;
        code = R50_NONE;
        if (c == 8'h24) begin
            code = CODE_DOLLAR;
        end else if (c == 8'h2E) begin
            code = R50_DOT;
        end else if (c == 8'h25) begin
            code = CODE_PERCENT;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            code = 6'(c - 8'h30) + R50_DIGIT_BASE;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            code = 6'(c - 8'h40);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            code = 6'(c - 8'h60);
        end
        return code;
    endfunction

    // Weight a code by its slot inside a word (0 = first, 1 = second, 2 = third)
    function automatic t_r50_word r50_weigh(input t_r50_code code, input logic [1:0] slot);
        t_r50_word w;
        case (slot)
            2'd0:    w = 16'(code * W_FIRST);
            2'd1:    w = 16'(code * W_SECOND);
            default: w = 16'(code);
        endcase
        return w;
    endfunction

endpackage

/* hdl/filename_to_radix50_packer_top.sv */
// Radix-50 filename packer, 6.3 format.
//
// Input channel (i_valid / o_ready): one beat per filename byte on
// i_char_code with i_end_of_name low, then one beat with i_end_of_name high
// that closes the name. A slash byte restarts the name from scratch.
// Output channel (o_valid / i_ready): one beat per closed name, carrying the
// two name words, the type word and o_name_legal. An illegal name comes out
// with all three words zero.
//
// Throughput: one input beat per cycle while o_ready is high. Each byte is
// decoded and added into the accumulators by a single constant-weight
// multiply-add in the cycle it is accepted. Latency: the result beat is valid
// in the cycle after the end beat is accepted, from the output register.
// Stall: while a result waits in the output register and i_ready is low,
// o_ready drops; byte beats keep flowing as soon as the register drains.
// Reset (i_rst_n low, synchronous): clear the position, the accumulators,
// the illegal flag and the output valid.
module filename_to_radix50_packer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_name,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_name_word_first,
    output logic [15:0] o_name_word_second,
    output logic [15:0] o_type_word,
    output logic        o_name_legal
);

    logic [3:0]  r_char_position, n_char_position;
    logic [15:0] r_word_first_acc, n_word_first_acc;
    logic [15:0] r_word_second_acc, n_word_second_acc;
    logic [15:0] r_type_acc, n_type_acc;
    logic        r_illegal_seen, n_illegal_seen;

    logic        r_out_valid;
    logic [15:0] r_out_first, r_out_second, r_out_type;
    logic        r_out_legal;

    logic                    in_beat;
    logic                    end_beat;
    fnr50_pkg::t_r50_code    code;
    logic [1:0]              slot;
    fnr50_pkg::t_r50_word    weighted;
    logic [3:0]              slot_pos;

    // Accept a new beat whenever the output register is empty or draining
    assign o_ready  = !r_out_valid || i_ready;
    assign in_beat  = i_valid && o_ready;
    assign end_beat = in_beat && i_end_of_name;

    assign code = fnr50_pkg::r50_code(i_char_code);

    // Slot inside the current word, taken from the position counter
    always_comb begin
        if (r_char_position < fnr50_pkg::POS_SECOND_WORD) begin
            slot_pos = r_char_position;
        end else if (r_char_position < fnr50_pkg::POS_NAME_FULL) begin
            slot_pos = r_char_position - fnr50_pkg::POS_SECOND_WORD;
        end else begin
            slot_pos = r_char_position - fnr50_pkg::POS_TYPE_START;
        end
        slot = slot_pos[1:0];
    end

    assign weighted = fnr50_pkg::r50_weigh(code, slot);

    always_comb begin
        n_char_position   = r_char_position;
        n_word_first_acc  = r_word_first_acc;
        n_word_second_acc = r_word_second_acc;
        n_type_acc        = r_type_acc;
        n_illegal_seen    = r_illegal_seen;
        if (in_beat) begin
            if (i_end_of_name || i_char_code == fnr50_pkg::ASCII_SLASH) begin
                // Restart the name
                n_char_position   = '0;
                n_word_first_acc  = '0;
                n_word_second_acc = '0;
                n_type_acc        = '0;
                n_illegal_seen    = 1'b0;
            end else if (!r_illegal_seen) begin
                if (code == fnr50_pkg::R50_NONE) begin
                    n_illegal_seen = 1'b1;
                end else if (code == fnr50_pkg::R50_DOT) begin
                    // A second dot is illegal; the first moves on to the type
                    if (r_char_position >= fnr50_pkg::POS_TYPE_START) begin
                        n_illegal_seen = 1'b1;
                    end else begin
                        n_char_position = fnr50_pkg::POS_TYPE_START;
                    end
                end else if (r_char_position < fnr50_pkg::POS_SECOND_WORD) begin
                    n_word_first_acc = r_word_first_acc + weighted;
                    n_char_position  = r_char_position + 4'd1;
                end else if (r_char_position < fnr50_pkg::POS_NAME_FULL) begin
                    n_word_second_acc = r_word_second_acc + weighted;
                    n_char_position   = r_char_position + 4'd1;
                end else if (r_char_position >= fnr50_pkg::POS_TYPE_START &&
                             r_char_position < fnr50_pkg::POS_TYPE_FULL) begin
                    n_type_acc      = r_type_acc + weighted;
                    n_char_position = r_char_position + 4'd1;
                end else begin
                    // Too many name or type characters
                    n_illegal_seen = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_position   <= '0;
            r_word_first_acc  <= '0;
            r_word_second_acc <= '0;
            r_type_acc        <= '0;
            r_illegal_seen    <= 1'b0;
        end else begin
            r_char_position   <= n_char_position;
            r_word_first_acc  <= n_word_first_acc;
            r_word_second_acc <= n_word_second_acc;
            r_type_acc        <= n_type_acc;
            r_illegal_seen    <= n_illegal_seen;
        end
    end

    // Output register: load on the end beat, hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (end_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_beat) begin
            r_out_first  <= r_illegal_seen ? 16'd0 : r_word_first_acc;
            r_out_second <= r_illegal_seen ? 16'd0 : r_word_second_acc;
            r_out_type   <= r_illegal_seen ? 16'd0 : r_type_acc;
            r_out_legal  <= !r_illegal_seen;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_name_word_first  = r_out_first;
    assign o_name_word_second = r_out_second;
    assign o_type_word        = r_out_type;
    assign o_name_legal       = r_out_legal;

`ifndef SYNTHESIS
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_beat |=> o_valid)
        else $error("end beat did not produce a result");

    a_end_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_beat |=> (r_char_position == 4'd0 && !r_illegal_seen &&
                      r_word_first_acc == 16'd0 && r_type_acc == 16'd0))
        else $error("state not cleared after end beat");

    a_illegal_zero_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_name_legal) |->
            (o_name_word_first == 16'd0 && o_name_word_second == 16'd0 &&
             o_type_word == 16'd0))
        else $error("illegal name carries nonzero words");

    a_position_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_position <= fnr50_pkg::POS_TYPE_FULL)
        else $error("character position out of range");
`endif

endmodule

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // One packed filename as it leaves the block
    typedef struct packed {
        fnr50_pkg::t_r50_word w_first;
        fnr50_pkg::t_r50_word w_second;
        fnr50_pkg::t_r50_word w_type;
        logic                 legal;
    } t_name_result;

    // One directed beat; typed rows carry a hand-written expected result
    typedef struct packed {
        logic [7:0]   ch;
        logic         fin;
        logic         typed;
        t_name_result want;
    } t_stim_row;

    localparam t_name_result NO_CHECK  = '0;
    localparam t_name_result EMPTY_OK  = '{16'd0, 16'd0, 16'd0, 1'b1};
    localparam t_name_result ILLEGAL   = '{16'd0, 16'd0, 16'd0, 1'b0};
    localparam t_name_result ALL_NINES = '{16'd63999, 16'd63999, 16'd63999, 1'b1};

    localparam logic [7:0] CH_DOT = 8'h2E;

    // Directed beats: extremes, separators and the special cases below. Only end
    // beats whose result is obvious get a typed expectation.
    localparam int DIR_COUNT = 28;
    localparam t_stim_row DIR_ROWS [DIR_COUNT] = '{
        // empty name straight out of reset
        '{8'h00, 1'b1, 1'b1, EMPTY_OK},
        // largest words: "999999.999", dot right after a full name
        '{"9", 1'b0, 1'b0, NO_CHECK}, '{"9", 1'b0, 1'b0, NO_CHECK},
        '{"9", 1'b0, 1'b0, NO_CHECK}, '{"9", 1'b0, 1'b0, NO_CHECK},
        '{"9", 1'b0, 1'b0, NO_CHECK}, '{"9", 1'b0, 1'b0, NO_CHECK},
        '{".", 1'b0, 1'b0, NO_CHECK},
        '{"9", 1'b0, 1'b0, NO_CHECK}, '{"9", 1'b0, 1'b0, NO_CHECK},
        '{"9", 1'b0, 1'b0, NO_CHECK},
        '{8'hFF, 1'b1, 1'b1, ALL_NINES},
        // NUL is illegal, then a slash wipes the illegal flag
        '{8'h00, 1'b0, 1'b0, NO_CHECK},
        '{"/", 1'b0, 1'b0, NO_CHECK},
        // lone dot is a legal empty name
        '{".", 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b1, 1'b1, EMPTY_OK},
        // lowercase, dollar, percent, then a second dot
        '{"a", 1'b0, 1'b0, NO_CHECK}, '{"$", 1'b0, 1'b0, NO_CHECK},
        '{"%", 1'b0, 1'b0, NO_CHECK}, '{".", 1'b0, 1'b0, NO_CHECK},
        '{".", 1'b0, 1'b0, NO_CHECK},
        '{8'h00, 1'b1, 1'b1, ILLEGAL},
        // fourth type character
        '{".", 1'b0, 1'b0, NO_CHECK}, '{"z", 1'b0, 1'b0, NO_CHECK},
        '{"z", 1'b0, 1'b0, NO_CHECK}, '{"z", 1'b0, 1'b0, NO_CHECK},
        '{"z", 1'b0, 1'b0, NO_CHECK},
        '{8'h7F, 1'b1, 1'b1, ILLEGAL}
    };

    // Idle and stall rates per random phase, in percent
    localparam int SRC_IDLE [4]   = '{0, 65, 0, 24};
    localparam int SINK_STALL [4] = '{0, 0, 65, 24};
    localparam int PHASE_BEATS    = 125;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_char_code   = 8'h00;
    logic        i_end_of_name = 1'b0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [15:0] o_name_word_first;
    logic [15:0] o_name_word_second;
    logic [15:0] o_type_word;
    logic        o_name_legal;

    // Shadow of the packer state
    logic [3:0]           name_pos;
    fnr50_pkg::t_r50_word acc_first;
    fnr50_pkg::t_r50_word acc_second;
    fnr50_pkg::t_r50_word acc_type;
    logic                 name_bad;

    t_name_result expected_names [$];
    int           err_count      = 0;
    int           beat_count     = 0;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    logic         typed_pending  = 1'b0;
    t_name_result typed_value    = NO_CHECK;

    filename_to_radix50_packer_top u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_char_code        (i_char_code),
        .i_end_of_name      (i_end_of_name),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_name_word_first  (o_name_word_first),
        .o_name_word_second (o_name_word_second),
        .o_type_word        (o_type_word),
        .o_name_legal       (o_name_legal)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake hangs
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Radix-50 code of one byte; R50_NONE for bytes outside the set
    function automatic fnr50_pkg::t_r50_code char_to_r50(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return fnr50_pkg::t_r50_code'(c - "A" + 8'd1);
        if (c >= "a" && c <= "z") return fnr50_pkg::t_r50_code'(c - "a" + 8'd1);
        if (c >= "0" && c <= "9")
            return fnr50_pkg::t_r50_code'(c - "0") + fnr50_pkg::R50_DIGIT_BASE;
        if (c == "$") return fnr50_pkg::CODE_DOLLAR;
        if (c == "%") return fnr50_pkg::CODE_PERCENT;
        if (c == ".") return fnr50_pkg::R50_DOT;
        return fnr50_pkg::R50_NONE;
    endfunction

    // Weighted value of a code in slot 0, 1 or 2 of a word
    function automatic fnr50_pkg::t_r50_word slot_value(input fnr50_pkg::t_r50_code code,
                                                        input logic [3:0] slot);
        fnr50_pkg::t_r50_word wide;
        wide = fnr50_pkg::t_r50_word'(code);
        if (slot == 4'd0) return wide * fnr50_pkg::W_FIRST;
        if (slot == 4'd1) return wide * fnr50_pkg::W_SECOND;
        return wide;
    endfunction

    function automatic void clear_name();
        name_pos   = '0;
        acc_first  = '0;
        acc_second = '0;
        acc_type   = '0;
        name_bad   = 1'b0;
    endfunction

    // Advance the shadow state by one accepted beat; queue the result of an end beat
    function automatic void absorb_beat(input logic [7:0] c, input logic fin);
        fnr50_pkg::t_r50_code code;
        t_name_result         res;
        if (fin) begin
            if (name_bad) res = ILLEGAL;
            else res = '{acc_first, acc_second, acc_type, 1'b1};
            expected_names.push_back(typed_pending ? typed_value : res);
            clear_name();
        end else if (c == fnr50_pkg::ASCII_SLASH) begin
            clear_name();
        end else if (!name_bad) begin
            code = char_to_r50(c);
            if (code == fnr50_pkg::R50_NONE) begin
                name_bad = 1'b1;
            end else if (code == fnr50_pkg::R50_DOT) begin
                if (name_pos >= fnr50_pkg::POS_TYPE_START) name_bad = 1'b1;
                else name_pos = fnr50_pkg::POS_TYPE_START;
            end else if (name_pos < fnr50_pkg::POS_SECOND_WORD) begin
                acc_first += slot_value(code, name_pos);
                name_pos++;
            end else if (name_pos < fnr50_pkg::POS_NAME_FULL) begin
                acc_second += slot_value(code, name_pos - fnr50_pkg::POS_SECOND_WORD);
                name_pos++;
            end else if (name_pos >= fnr50_pkg::POS_TYPE_START &&
                         name_pos < fnr50_pkg::POS_TYPE_FULL) begin
                acc_type += slot_value(code, name_pos - fnr50_pkg::POS_TYPE_START);
                name_pos++;
            end else begin
                // seventh name character or fourth type character
                name_bad = 1'b1;
            end
        end
    endfunction

    function automatic void report_miss(input string what, input t_name_result want,
                                        input t_name_result got);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s: expected %0d %0d %0d legal %0d, got %0d %0d %0d legal %0d",
                     $realtime, what, want.w_first, want.w_second, want.w_type, want.legal,
                     got.w_first, got.w_second, got.w_type, got.legal);
    endfunction

    // Sample both channels at the rising edge. Check the result beat first:
    // the block answers an end beat no earlier than the next cycle.
    always @(posedge i_clk) begin : watch
        t_name_result got;
        t_name_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = '{o_name_word_first, o_name_word_second, o_type_word, o_name_legal};
                if (expected_names.size() == 0) begin
                    report_miss("result with nothing pending", NO_CHECK, got);
                end else begin
                    want = expected_names.pop_front();
                    if (got.w_first !== want.w_first || got.w_second !== want.w_second ||
                        got.w_type !== want.w_type || got.legal !== want.legal)
                        report_miss("mismatch", want, got);
                end
            end
            if (i_valid && o_ready)
                absorb_beat(i_char_code, i_end_of_name);
        end
    end

    // Receiver: stall at random, rate set by the running phase
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Present one beat at a falling edge, hold it until accepted.
    // Idle cycles drop valid and scramble the payload.
    task automatic send_beat(input logic [7:0] c, input logic fin, input logic typed,
                             input t_name_result want);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid       <= 1'b0;
            i_char_code   <= 8'($urandom_range(255));
            i_end_of_name <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        typed_pending = typed;
        typed_value   = want;
        i_valid       <= 1'b1;
        i_char_code   <= c;
        i_end_of_name <= fin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beat_count++;
    endtask

    function automatic logic [7:0] pick_legal_char();
        case ($urandom_range(3))
            0:       return 8'("A" + $urandom_range(25));
            1:       return 8'("a" + $urandom_range(25));
            2:       return 8'("0" + $urandom_range(9));
            default: return $urandom_range(1) ? 8'("$") : 8'("%");
        endcase
    endfunction

    // Mostly noise-free characters; now and then any byte at all
    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 4) return 8'($urandom_range(255));
        return pick_legal_char();
    endfunction

    // Mostly well-formed names with random content; some overflow a field,
    // carry a second dot, or start with junk that a slash throws away.
    task automatic send_random_name();
        int name_len;
        int type_len;
        int junk_len;
        if ($urandom_range(99) < 15) begin
            junk_len = $urandom_range(4);
            repeat (junk_len) send_beat(8'($urandom_range(255)), 1'b0, 1'b0, NO_CHECK);
            send_beat(fnr50_pkg::ASCII_SLASH, 1'b0, 1'b0, NO_CHECK);
        end
        name_len = ($urandom_range(99) < 10) ? 7 : $urandom_range(6);
        repeat (name_len) send_beat(pick_char(), 1'b0, 1'b0, NO_CHECK);
        if ($urandom_range(99) < 70) begin
            send_beat(CH_DOT, 1'b0, 1'b0, NO_CHECK);
            type_len = ($urandom_range(99) < 10) ? 4 : $urandom_range(3);
            repeat (type_len) send_beat(pick_char(), 1'b0, 1'b0, NO_CHECK);
            if ($urandom_range(99) < 5) begin
                send_beat(CH_DOT, 1'b0, 1'b0, NO_CHECK);
                send_beat(pick_legal_char(), 1'b0, 1'b0, NO_CHECK);
            end
        end
        // char_code is don't-care on the end beat: drive it at random
        send_beat(8'($urandom_range(255)), 1'b1, 1'b0, NO_CHECK);
    endtask

    initial begin : stimulus
        int wait_cycles;
        clear_name();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_COUNT; k++)
            send_beat(DIR_ROWS[k].ch, DIR_ROWS[k].fin, DIR_ROWS[k].typed, DIR_ROWS[k].want);

        // Random part in four phases: free flow, sender idling, receiver
        // stalling, then both
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = SRC_IDLE[ph];
            sink_stall_pct = SINK_STALL[ph];
            while (beat_count < DIR_COUNT + (ph + 1) * PHASE_BEATS)
                send_random_name();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        wait_cycles = 0;
        while (expected_names.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (5) @(posedge i_clk);
        if (expected_names.size() != 0) begin
            err_count += expected_names.size();
            $display("%0d expected results never arrived", expected_names.size());
        end

        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
